FILE: src/pre_pkg.sv
package pre_pkg;

    localparam int MAX_RUN_LENGTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF    = 2;

    localparam int BYTE_W = 8;
    localparam int OFF_W  = 32;
    localparam int CFG_W  = 6;
    // Wide enough for any run length the block supports (up to 63).
    localparam int CNT_W  = 6;

    localparam logic [CFG_W-1:0]  MIN_RUN_RESET = 6'd4;
    localparam logic [BYTE_W-1:0] NEWLINE_BYTE  = 8'h0A;
    localparam logic [BYTE_W-1:0] TAB_BYTE      = 8'h09;
    localparam logic [BYTE_W-1:0] PRINT_LO      = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HI      = 8'h7E;
    localparam logic [OFF_W-1:0]  OFF_MAX       = '1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_BYTE,
        OP_REPLAY,
        OP_NEWLINE
    } pre_op_t;

    // One queue entry per input transaction that yields results.
    typedef struct packed {
        pre_op_t              op;
        logic [BYTE_W-1:0]    data;
        logic [CNT_W-1:0]     count;
        logic [OFF_W-1:0]     offset;
        logic                 add_nl;
    } pre_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pre_queue_status_t;

    typedef struct packed {
        logic replay_done;
    } pre_back_status_t;

    function automatic logic is_printable(input logic [BYTE_W-1:0] b);
        return ((b >= PRINT_LO) && (b <= PRINT_HI)) || (b == TAB_BYTE);
    endfunction

endpackage

FILE: src/pre_if.sv
interface pre_in_if import pre_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_data;

    modport source (output valid, output in_byte, output end_of_data, input ready);
    modport sink   (input valid, input in_byte, input end_of_data, output ready);
endinterface

interface pre_out_if import pre_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              string_start;
    logic [OFF_W-1:0]  start_offset;
    logic              last;

    modport source (output valid, output out_byte, output string_start,
                    output start_offset, output last, input ready);
    modport sink   (input valid, input out_byte, input string_start,
                    input start_offset, input last, output ready);
endinterface

FILE: src/pre_ram.sv
module pre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/pre_cmd_queue.sv
module pre_cmd_queue import pre_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pre_cmd_t          push_cmd,
    input  logic              pop,
    output pre_cmd_t          head_cmd,
    output pre_queue_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    pre_cmd_t        entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]   fill_reg, fill_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = FW'(fill_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            fill_next = FW'(fill_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd     = entry_reg[rd_ptr_reg];
    assign status.full  = (fill_reg == FW'(DEPTH));
    assign status.empty = (fill_reg == '0);

endmodule

FILE: src/pre_front.sv
module pre_front import pre_pkg::*; #(
    parameter int MAX_RUN_LENGTH = MAX_RUN_LENGTH_DEF,
    localparam int AW = (MAX_RUN_LENGTH > 1) ? $clog2(MAX_RUN_LENGTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    pre_in_if.sink            in_ch,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    output logic              push,
    output pre_cmd_t          push_cmd,
    input  pre_queue_status_t q_status,
    input  pre_back_status_t  back_status,
    output logic              ram_we,
    output logic [AW-1:0]     ram_waddr,
    output logic [BYTE_W-1:0] ram_wdata
);

    localparam int CW = $clog2(MAX_RUN_LENGTH + 1);

    logic [CFG_W-1:0] min_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic             emitting_reg, emitting_next;
    logic [OFF_W-1:0] offset_reg, offset_next;
    logic             busy_reg, busy_next;

    logic             accept;
    logic             printable;
    logic [CW-1:0]    eff_min;
    logic [CW-1:0]    cnt_new;

    // A byte that may start or extend a held run waits while a replay reads the buffer.
    assign in_ch.ready = !q_status.full && (emitting_reg || !busy_reg);
    assign accept      = in_ch.valid && in_ch.ready;
    assign printable   = is_printable(in_ch.in_byte);

    always_comb
    begin
        priority if (min_reg == '0)
        begin
            eff_min = CW'(1);
        end
        else if (int'(min_reg) > MAX_RUN_LENGTH)
        begin
            eff_min = CW'(MAX_RUN_LENGTH);
        end
        else
        begin
            eff_min = CW'(min_reg);
        end
    end

    assign cnt_new = (int'(count_reg) < MAX_RUN_LENGTH) ? CW'(count_reg + 1'b1) : count_reg;

    always_comb
    begin
        count_next      = count_reg;
        emitting_next   = emitting_reg;
        offset_next     = offset_reg;
        busy_next       = busy_reg && !back_status.replay_done;
        push_cmd.op     = OP_NONE;
        push_cmd.data   = in_ch.in_byte;
        push_cmd.count  = CNT_W'(cnt_new);
        push_cmd.offset = offset_reg - OFF_W'(cnt_new) + OFF_W'(1);
        push_cmd.add_nl = 1'b0;
        ram_we          = 1'b0;

        if (accept)
        begin
            if (offset_reg != OFF_MAX)
            begin
                offset_next = offset_reg + OFF_W'(1);
            end

            if (printable)
            begin
                if (emitting_reg)
                begin
                    push_cmd.op = OP_BYTE;
                end
                else
                begin
                    ram_we = (int'(count_reg) < MAX_RUN_LENGTH);
                    if (cnt_new >= eff_min)
                    begin
                        push_cmd.op   = OP_REPLAY;
                        emitting_next = 1'b1;
                        count_next    = '0;
                        busy_next     = 1'b1;
                    end
                    else
                    begin
                        count_next = cnt_new;
                    end
                end
            end
            else
            begin
                if (emitting_reg)
                begin
                    push_cmd.op = OP_NEWLINE;
                end
                emitting_next = 1'b0;
                count_next    = '0;
            end

            if (in_ch.end_of_data)
            begin
                if (emitting_next)
                begin
                    push_cmd.add_nl = 1'b1;
                end
                emitting_next = 1'b0;
                count_next    = '0;
                offset_next   = '0;
            end
        end
    end

    assign push      = accept && (push_cmd.op != OP_NONE);
    assign ram_waddr = count_reg[AW-1:0];
    assign ram_wdata = in_ch.in_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg      <= MIN_RUN_RESET;
            count_reg    <= '0;
            emitting_reg <= 1'b0;
            offset_reg   <= '0;
            busy_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_reg <= cfg_wdata;
            end
            count_reg    <= count_next;
            emitting_reg <= emitting_next;
            offset_reg   <= offset_next;
            busy_reg     <= busy_next;
        end
    end

endmodule

FILE: src/pre_back.sv
module pre_back import pre_pkg::*; #(
    parameter int MAX_RUN_LENGTH = MAX_RUN_LENGTH_DEF,
    localparam int AW = (MAX_RUN_LENGTH > 1) ? $clog2(MAX_RUN_LENGTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pre_cmd_t          head_cmd,
    input  pre_queue_status_t q_status,
    output logic              pop,
    output pre_back_status_t  back_status,
    output logic              ram_re,
    output logic [AW-1:0]     ram_raddr,
    input  logic [BYTE_W-1:0] ram_rdata,
    pre_out_if.source         out_ch
);

    localparam int CW = $clog2(MAX_RUN_LENGTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_NL    = 4'b1000
    } pre_back_state_t;

    pre_back_state_t   state_reg, state_next;
    pre_cmd_t          cmd_reg, cmd_next;
    logic [CW-1:0]     idx_reg, idx_next;

    logic              o_valid_reg, o_valid_next;
    logic [BYTE_W-1:0] o_byte_reg, o_byte_next;
    logic              o_start_reg, o_start_next;
    logic [OFF_W-1:0]  o_off_reg, o_off_next;
    logic              o_last_reg, o_last_next;

    logic              load;
    logic              from_ram;
    logic              final_byte;

    assign load       = !o_valid_reg || out_ch.ready;
    assign from_ram   = (cmd_reg.op == OP_REPLAY);
    assign final_byte = !from_ram || ((CNT_W'(idx_reg) + CNT_W'(1)) == cmd_reg.count);
    assign ram_raddr  = idx_reg[AW-1:0];

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        pop          = 1'b0;
        ram_re       = 1'b0;
        back_status.replay_done = 1'b0;
        o_valid_next = o_valid_reg && !out_ch.ready;
        o_byte_next  = o_byte_reg;
        o_start_next = o_start_reg;
        o_off_next   = o_off_reg;
        o_last_next  = o_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head_cmd;
                    idx_next = '0;
                    unique case (head_cmd.op)
                        OP_BYTE:    state_next = ST_EMIT;
                        OP_REPLAY:  state_next = ST_FETCH;
                        OP_NEWLINE: state_next = ST_NL;
                        OP_NONE:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FETCH:
            begin
                ram_re     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    o_valid_next = 1'b1;
                    o_byte_next  = from_ram ? ram_rdata : cmd_reg.data;
                    o_start_next = from_ram && (idx_reg == '0);
                    o_off_next   = (from_ram && (idx_reg == '0)) ? cmd_reg.offset : '0;
                    o_last_next  = final_byte && !cmd_reg.add_nl;
                    if (!final_byte)
                    begin
                        idx_next   = CW'(idx_reg + 1'b1);
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        back_status.replay_done = from_ram;
                        state_next = cmd_reg.add_nl ? ST_NL : ST_IDLE;
                    end
                end
            end
            ST_NL:
            begin
                if (load)
                begin
                    o_valid_next = 1'b1;
                    o_byte_next  = NEWLINE_BYTE;
                    o_start_next = 1'b0;
                    o_off_next   = '0;
                    o_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        idx_reg     <= idx_next;
        o_byte_reg  <= o_byte_next;
        o_start_reg <= o_start_next;
        o_off_reg   <= o_off_next;
        o_last_reg  <= o_last_next;
    end

    assign out_ch.valid        = o_valid_reg;
    assign out_ch.out_byte     = o_byte_reg;
    assign out_ch.string_start = o_start_reg;
    assign out_ch.start_offset = o_off_reg;
    assign out_ch.last         = o_last_reg;

endmodule

FILE: src/printable_run_extractor_top.sv
// Printable run extractor: scans bytes for runs of printable characters (0x20..0x7E and
// tab), holds a run in a small buffer RAM until it reaches min_run_length, then emits
// it with the run's start offset on the first byte and a newline when it ends. The front
// classifies each input transaction and queues at most one command for it (QUEUE_DEPTH
// entries); the back sequencer turns commands into output transactions. For a
// pass-through byte it dequeues the command, then loads the output; for a released run
// it dequeues the command, then per byte reads the buffer RAM and loads the output, and
// a closing newline adds one more output load. Input is held off while a released run
// is still being read out of the buffer and the next byte could start a new run, or when
// the queue is full. Bytes that produce no output queue nothing.
module printable_run_extractor_top import pre_pkg::*; #(
    parameter int MAX_RUN_LENGTH = MAX_RUN_LENGTH_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    pre_in_if.sink           in_ch,
    pre_out_if.source        out_ch,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int AW = (MAX_RUN_LENGTH > 1) ? $clog2(MAX_RUN_LENGTH) : 1;

    logic              push;
    pre_cmd_t          push_cmd;
    logic              pop;
    pre_cmd_t          head_cmd;
    pre_queue_status_t q_status;
    pre_back_status_t  back_status;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    pre_front #(
        .MAX_RUN_LENGTH (MAX_RUN_LENGTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .push        (push),
        .push_cmd    (push_cmd),
        .q_status    (q_status),
        .back_status (back_status),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata)
    );

    pre_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    pre_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_RUN_LENGTH)
    ) u_run_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pre_back #(
        .MAX_RUN_LENGTH (MAX_RUN_LENGTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .q_status    (q_status),
        .pop         (pop),
        .back_status (back_status),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .out_ch      (out_ch)
    );

endmodule
